// File: src/fmfc_pkg.sv
// ----------------------------------------------------------------------------
// fmfc_pkg
// Shared types and helpers for the first-match flow classifier: the queued
// item format, the stored rule format and the prefix mask decode.
// ----------------------------------------------------------------------------
package fmfc_pkg;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_RULE   = 1'b1;

  localparam logic [31:0] ADDR_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [4:0]  idx;
    logic [2:0]  ver;
    logic [7:0]  proto;
    logic [31:0] s_addr;
    logic [31:0] s_mask;
    logic [15:0] s_port;
    logic [31:0] d_addr;
    logic [31:0] d_mask;
    logic [15:0] d_port;
    logic [7:0]  pair;
    logic [1:0]  attr;
  } q_item_t;

  typedef struct packed {
    logic [2:0]  ver;
    logic [7:0]  proto;
    logic [31:0] s_addr;
    logic [31:0] s_mask;
    logic [15:0] s_port;
    logic [31:0] d_addr;
    logic [31:0] d_mask;
    logic [15:0] d_port;
    logic [7:0]  pair;
    logic [1:0]  attr;
  } rule_t;

  // compare mask of one rule side: wildcard, exact, or leading prefix bits
  function automatic logic [31:0] side_mask(input logic [31:0] addr,
                                            input logic [7:0]  pref);
    logic [31:0] m;
    m = ADDR_ONES;
    if (addr == 32'd0) begin
      m = 32'd0;
    end else if (pref != 8'd0 && pref < 8'd32) begin
      m = ~(ADDR_ONES >> pref[4:0]);
    end
    return m;
  endfunction

endpackage

// File: src/first_match_flow_classifier.sv
// ----------------------------------------------------------------------------
// first_match_flow_classifier
// A rule write in the back end gives no result. A packet with version 0, or
// with a rule count of 0, gets a no-match result without a search; any other
// packet reads table entries one after another, up to the first match or
// min(rule_count, MAX_RULES) entries, since the rule table has one read port
// and the search walks it in index order. Items pass a decode front end and
// a two-entry queue first, so input is taken while the back end searches,
// and a finished result waits in the output register.
// ----------------------------------------------------------------------------
module first_match_flow_classifier #(
  parameter int MAX_RULES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_rule_count,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [4:0]  in_rule_index,
  input  logic [2:0]  in_ip_version,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_address,
  input  logic [7:0]  in_src_prefix,
  input  logic [15:0] in_src_port,
  input  logic [31:0] in_dst_address,
  input  logic [7:0]  in_dst_prefix,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_color_pair,
  input  logic [1:0]  in_attr_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  output logic [4:0]  out_hit_index,
  output logic [7:0]  out_pair_out,
  output logic        out_bold,
  output logic        out_blink
);
  import fmfc_pkg::*;

  logic    q_full;
  logic    q_push;
  q_item_t q_item;
  logic    q_pop;
  logic    head_valid;
  q_item_t head_item;

  fmfc_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_rule_index  (in_rule_index),
    .in_ip_version  (in_ip_version),
    .in_protocol    (in_protocol),
    .in_src_address (in_src_address),
    .in_src_prefix  (in_src_prefix),
    .in_src_port    (in_src_port),
    .in_dst_address (in_dst_address),
    .in_dst_prefix  (in_dst_prefix),
    .in_dst_port    (in_dst_port),
    .in_color_pair  (in_color_pair),
    .in_attr_bits   (in_attr_bits),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  fmfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  fmfc_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_rule_count (cfg_rule_count),
    .head_valid     (head_valid),
    .head_item      (head_item),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_matched    (out_matched),
    .out_hit_index  (out_hit_index),
    .out_pair_out   (out_pair_out),
    .out_bold       (out_bold),
    .out_blink      (out_blink)
  );

endmodule

// File: src/fmfc_front.sv
// ----------------------------------------------------------------------------
// fmfc_front
// Input side: accepts items and decodes rule sides into address and mask
// compare form before they enter the queue.
// ----------------------------------------------------------------------------
module fmfc_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [4:0]        in_rule_index,
  input  logic [2:0]        in_ip_version,
  input  logic [7:0]        in_protocol,
  input  logic [31:0]       in_src_address,
  input  logic [7:0]        in_src_prefix,
  input  logic [15:0]       in_src_port,
  input  logic [31:0]       in_dst_address,
  input  logic [7:0]        in_dst_prefix,
  input  logic [15:0]       in_dst_port,
  input  logic [7:0]        in_color_pair,
  input  logic [1:0]        in_attr_bits,
  input  logic              q_full,
  output logic              q_push,
  output fmfc_pkg::q_item_t q_item
);
  import fmfc_pkg::*;

  logic [31:0] s_mask;
  logic [31:0] d_mask;
  logic        is_rule;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign is_rule  = (in_kind == KIND_RULE);
  assign s_mask   = side_mask(in_src_address, in_src_prefix);
  assign d_mask   = side_mask(in_dst_address, in_dst_prefix);

  always_comb begin
    q_item.kind   = in_kind;
    q_item.idx    = in_rule_index;
    q_item.ver    = in_ip_version;
    q_item.proto  = in_protocol;
    q_item.s_addr = is_rule ? (in_src_address & s_mask) : in_src_address;
    q_item.s_mask = s_mask;
    q_item.s_port = in_src_port;
    q_item.d_addr = is_rule ? (in_dst_address & d_mask) : in_dst_address;
    q_item.d_mask = d_mask;
    q_item.d_port = in_dst_port;
    q_item.pair   = in_color_pair;
    q_item.attr   = in_attr_bits;
  end

endmodule

// File: src/fmfc_queue.sv
// ----------------------------------------------------------------------------
// fmfc_queue
// Two-entry queue between the decode front and the search back end.
// ----------------------------------------------------------------------------
module fmfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fmfc_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output fmfc_pkg::q_item_t head_item
);
  import fmfc_pkg::*;

  q_item_t    items_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = items_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      items_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: src/fmfc_back.sv
// ----------------------------------------------------------------------------
// fmfc_back
// Execution side: writes rules into the table and runs the first-match
// search, one table entry per cycle, into the result register.
// ----------------------------------------------------------------------------
module fmfc_back #(
  parameter int MAX_RULES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [5:0]        cfg_rule_count,
  input  logic              head_valid,
  input  fmfc_pkg::q_item_t head_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_matched,
  output logic [4:0]        out_hit_index,
  output logic [7:0]        out_pair_out,
  output logic              out_bold,
  output logic              out_blink
);
  import fmfc_pkg::*;

  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CW = $clog2(MAX_RULES + 1);

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t      state_r;
  logic [5:0]  rule_count_r;
  logic [AW-1:0] idx_r;
  logic        out_valid_r;
  logic        matched_r;
  logic [4:0]  hit_index_r;
  logic [7:0]  pair_r;
  logic        bold_r;
  logic        blink_r;

  rule_t       mem_r [MAX_RULES];
  rule_t       rdata_r;
  rule_t       wdata;
  logic        wr_en;
  logic        rd_en;
  logic [AW-1:0] rd_addr;

  logic [CW-1:0] limit;
  logic        hit;
  logic        last;
  logic        out_free;
  logic        out_load;
  logic        in_range;
  logic        no_search;

  assign cfg_ready = 1'b1;

  assign limit = (32'(rule_count_r) > 32'(MAX_RULES)) ? CW'(MAX_RULES)
                                                      : CW'(rule_count_r);
  assign last      = ((32'(idx_r) + 32'd1) == 32'(limit));
  assign out_free  = !out_valid_r || !out_stall;
  assign in_range  = (32'(head_item.idx) < 32'(MAX_RULES));
  assign no_search = (head_item.ver == 3'd0) || (limit == CW'(0));

  assign hit = (rdata_r.ver == 3'd0 || rdata_r.ver == head_item.ver)
            && (rdata_r.proto == 8'd0 || rdata_r.proto == head_item.proto)
            && ((head_item.s_addr & rdata_r.s_mask) == rdata_r.s_addr)
            && (rdata_r.s_port == 16'd0 || rdata_r.s_port == head_item.s_port)
            && ((head_item.d_addr & rdata_r.d_mask) == rdata_r.d_addr)
            && (rdata_r.d_port == 16'd0 || rdata_r.d_port == head_item.d_port);

  always_comb begin
    wdata.ver    = head_item.ver;
    wdata.proto  = head_item.proto;
    wdata.s_addr = head_item.s_addr;
    wdata.s_mask = head_item.s_mask;
    wdata.s_port = head_item.s_port;
    wdata.d_addr = head_item.d_addr;
    wdata.d_mask = head_item.d_mask;
    wdata.d_port = head_item.d_port;
    wdata.pair   = head_item.pair;
    wdata.attr   = head_item.attr;
  end

  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_r + AW'(1);
    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          if (head_item.kind == KIND_RULE) begin
            pop   = 1'b1;
            wr_en = in_range;
          end else if (no_search) begin
            pop      = out_free;
            out_load = out_free;
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(0);
          end
        end
      end
      S_SEARCH: begin
        if (hit || last) begin
          pop      = out_free;
          out_load = out_free;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // rule table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[AW'(head_item.idx)] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rule_count_r <= 6'd0;
      out_valid_r  <= 1'b0;
      idx_r        <= AW'(0);
    end else begin
      if (cfg_valid && cfg_ready) begin
        rule_count_r <= cfg_rule_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (head_valid && head_item.kind == KIND_PACKET) begin
            if (no_search) begin
              if (out_free) begin
                matched_r   <= 1'b0;
                hit_index_r <= 5'd0;
                pair_r      <= 8'd0;
                bold_r      <= 1'b0;
                blink_r     <= 1'b0;
              end
            end else begin
              idx_r   <= AW'(0);
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit || last) begin
            if (out_free) begin
              matched_r   <= hit;
              hit_index_r <= hit ? 5'(idx_r) : 5'd0;
              pair_r      <= hit ? rdata_r.pair : 8'd0;
              bold_r      <= hit && rdata_r.attr[0];
              blink_r     <= hit && rdata_r.attr[1];
              state_r     <= S_IDLE;
            end
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_matched   = matched_r;
  assign out_hit_index = hit_index_r;
  assign out_pair_out  = pair_r;
  assign out_bold      = bold_r;
  assign out_blink     = blink_r;

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-match flow classifier. It loads rule
// tables, classifies packets aimed at stored rules (plus bit-flipped and
// random noise packets), and checks every classification result against an
// in-bench rule search, over several rule counts and with random idling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fmfc_pkg::*;

  localparam int TABLE_DEPTH    = 32;
  localparam int ITEM_TARGET    = 1450;
  localparam int SETTLE_CYCLES  = 10;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic        kind;
    logic [4:0]  slot;
    logic [2:0]  version;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [7:0]  src_len;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [7:0]  dst_len;
    logic [15:0] dst_port;
    logic [7:0]  pair;
    logic [1:0]  attr;
  } flow_item_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] index;
    logic [7:0] pair;
    logic       bold;
    logic       blink;
  } verdict_t;

  class flow_verdicts;
    flow_item_t rules[TABLE_DEPTH];
    logic [5:0] search_count;
    verdict_t   expected_verdicts[$];
    int         errors;

    function new();
      search_count = '0;
      errors = 0;
    endfunction

    function void set_count(input logic [5:0] n);
      search_count = n;
    endfunction

    function bit side_hit(input logic [31:0] r_addr, input logic [7:0] r_len,
                          input logic [15:0] r_port, input logic [31:0] addr,
                          input logic [15:0] port);
      logic [31:0] ones;
      logic [31:0] keep;
      ones = '1;
      if (r_addr != 32'd0) begin
        if (r_len == 8'd0 || r_len >= 8'd32) begin
          keep = ones;
        end else begin
          keep = ~(ones >> r_len);
        end
        if ((addr & keep) != (r_addr & keep)) return 1'b0;
      end
      if (r_port != 16'd0 && port != r_port) return 1'b0;
      return 1'b1;
    endfunction

    function verdict_t classify_packet(input flow_item_t p);
      verdict_t   v;
      flow_item_t r;
      int         depth;
      v = '0;
      depth = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
      if (p.version == 3'd0) return v;
      for (int i = 0; i < depth; i++) begin
        r = rules[i];
        if (r.version != 3'd0 && r.version != p.version) continue;
        if (r.proto != 8'd0 && r.proto != p.proto) continue;
        if (!side_hit(r.src_addr, r.src_len, r.src_port, p.src_addr, p.src_port)) continue;
        if (!side_hit(r.dst_addr, r.dst_len, r.dst_port, p.dst_addr, p.dst_port)) continue;
        v.hit   = 1'b1;
        v.index = 5'(i);
        v.pair  = r.pair;
        v.bold  = r.attr[0];
        v.blink = r.attr[1];
        return v;
      end
      return v;
    endfunction

    function void note_item(input flow_item_t it);
      if (it.kind == KIND_RULE) begin
        rules[it.slot] = it;
      end else begin
        expected_verdicts.push_back(classify_packet(it));
      end
    endfunction

    function void flag(input string field, input int want, input int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(input verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_verdicts.pop_front();
      flag("matched", want.hit, got.hit);
      flag("hit_index", want.index, got.index);
      flag("pair_out", want.pair, got.pair);
      flag("bold", want.bold, got.bold);
      flag("blink", want.blink, got.blink);
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_rule_count;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [4:0]  in_rule_index;
  logic [2:0]  in_ip_version;
  logic [7:0]  in_protocol;
  logic [31:0] in_src_address;
  logic [7:0]  in_src_prefix;
  logic [15:0] in_src_port;
  logic [31:0] in_dst_address;
  logic [7:0]  in_dst_prefix;
  logic [15:0] in_dst_port;
  logic [7:0]  in_color_pair;
  logic [1:0]  in_attr_bits;
  logic        out_valid;
  logic        out_stall;
  logic        out_matched;
  logic [4:0]  out_hit_index;
  logic [7:0]  out_pair_out;
  logic        out_bold;
  logic        out_blink;

  flow_verdicts sb = new();
  bit           calm = 1'b0;
  int           issued = 0;
  int           quiet_left = 0;
  int           idle_cycles = 0;

  first_match_flow_classifier #(
    .MAX_RULES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_rule_count(cfg_rule_count),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_rule_index(in_rule_index),
    .in_ip_version(in_ip_version),
    .in_protocol(in_protocol),
    .in_src_address(in_src_address),
    .in_src_prefix(in_src_prefix),
    .in_src_port(in_src_port),
    .in_dst_address(in_dst_address),
    .in_dst_prefix(in_dst_prefix),
    .in_dst_port(in_dst_port),
    .in_color_pair(in_color_pair),
    .in_attr_bits(in_attr_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_matched(out_matched),
    .out_hit_index(out_hit_index),
    .out_pair_out(out_pair_out),
    .out_bold(out_bold),
    .out_blink(out_blink)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic flow_item_t flow(input logic kind, input logic [4:0] slot,
                                      input logic [2:0] version, input logic [7:0] proto,
                                      input logic [31:0] src_addr, input logic [7:0] src_len,
                                      input logic [15:0] src_port, input logic [31:0] dst_addr,
                                      input logic [7:0] dst_len, input logic [15:0] dst_port,
                                      input logic [7:0] pair, input logic [1:0] attr);
    flow_item_t it;
    it = '{kind, slot, version, proto, src_addr, src_len, src_port,
           dst_addr, dst_len, dst_port, pair, attr};
    return it;
  endfunction

  function automatic logic [31:0] random_addr();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return {8'd10, 8'($urandom_range(0, 3)), 16'($urandom)};
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] random_prefix();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd32;
      2: return 8'($urandom_range(1, 31));
      3: return 8'($urandom_range(33, 128));
      4: return 8'd128;
      default: return 8'($urandom_range(8, 24));
    endcase
  endfunction

  function automatic logic [15:0] random_port();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 1024));
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic flow_item_t random_rule(input logic [4:0] slot);
    flow_item_t r;
    r.kind = KIND_RULE;
    r.slot = slot;
    case ($urandom_range(0, 3))
      0: r.version = 3'd0;
      1: r.version = 3'd4;
      2: r.version = 3'd6;
      default: r.version = 3'($urandom_range(0, 6));
    endcase
    case ($urandom_range(0, 3))
      0: r.proto = 8'd0;
      1: r.proto = 8'd6;
      2: r.proto = 8'd17;
      default: r.proto = 8'($urandom);
    endcase
    r.src_addr = random_addr();
    r.src_len  = random_prefix();
    r.src_port = random_port();
    r.dst_addr = random_addr();
    r.dst_len  = random_prefix();
    r.dst_port = random_port();
    r.pair     = 8'($urandom);
    r.attr     = 2'($urandom);
    return r;
  endfunction

  // an address that passes the rule's compare, random in the bits it ignores
  function automatic logic [31:0] fit_addr(input logic [31:0] a, input logic [7:0] len);
    logic [31:0] ones;
    logic [31:0] keep;
    ones = '1;
    if (a == 32'd0) return $urandom;
    keep = (len == 8'd0 || len >= 8'd32) ? ones : ~(ones >> len);
    return (a & keep) | ($urandom & ~keep);
  endfunction

  task automatic send_item(input flow_item_t it);
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_rule_index  <= it.slot;
    in_ip_version  <= it.version;
    in_protocol    <= it.proto;
    in_src_address <= it.src_addr;
    in_src_prefix  <= it.src_len;
    in_src_port    <= it.src_port;
    in_dst_address <= it.dst_addr;
    in_dst_prefix  <= it.dst_len;
    in_dst_port    <= it.dst_port;
    in_color_pair  <= it.pair;
    in_attr_bits   <= it.attr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    issued++;
    if (!calm) begin
      if (quiet_left > 0) begin
        quiet_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        quiet_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 6);
      end
    end
  endtask

  task automatic set_rule_count(input logic [5:0] n);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_rule_count <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_count(n);
  endtask

  // result side
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_verdict({out_matched, out_hit_index, out_pair_out, out_bold, out_blink});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_match_flow_classifier test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int run;
    out_stall <= 1'b0;
    forever begin
      if (calm) begin
        @(posedge clk);
      end else begin
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
        repeat (run) @(posedge clk);
        if (!calm) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 16)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    flow_item_t it;
    flow_item_t r;
    int         schedule[5];
    int         phase;
    int         len;
    int         depth;
    int         k;
    logic [5:0] n;

    schedule = '{32, 0, 63, 1, 33};
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_rule_count <= '0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_PACKET;
    in_rule_index  <= '0;
    in_ip_version  <= '0;
    in_protocol    <= '0;
    in_src_address <= '0;
    in_src_prefix  <= '0;
    in_src_port    <= '0;
    in_dst_address <= '0;
    in_dst_prefix  <= '0;
    in_dst_port    <= '0;
    in_color_pair  <= '0;
    in_attr_bits   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty search after reset
    send_item(flow(KIND_PACKET, 5'd31, 3'd4, 8'd6, 32'h0A00_0001, 8'd128, 16'd1234,
                   32'h0, 8'd0, 16'd80, 8'hFF, 2'd3));
    // exact, prefix, saturated prefix, one-bit prefix, catch-all
    send_item(flow(KIND_RULE, 5'd0, 3'd4, 8'd6, 32'h0A00_0001, 8'd0, 16'd1234,
                   32'h0, 8'd7, 16'd80, 8'h11, 2'd1));
    send_item(flow(KIND_RULE, 5'd1, 3'd0, 8'd17, 32'hC0A8_0000, 8'd16, 16'd0,
                   32'hFFFF_FFFF, 8'd128, 16'd0, 8'h22, 2'd2));
    send_item(flow(KIND_RULE, 5'd2, 3'd6, 8'd0, 32'h8000_0000, 8'd1, 16'hFFFF,
                   32'hC0A8_0101, 8'd32, 16'd0, 8'hFF, 2'd3));
    send_item(flow(KIND_RULE, 5'd3, 3'd4, 8'hFF, 32'hFFFF_FFFE, 8'd31, 16'd1,
                   32'h0102_0304, 8'd33, 16'hFFFF, 8'h00, 2'd0));
    send_item(flow(KIND_RULE, 5'd4, 3'd0, 8'd0, 32'h0, 8'd8, 16'd0,
                   32'h0, 8'd0, 16'd0, 8'hA5, 2'd3));
    set_rule_count(6'd5);
    send_item(flow(KIND_PACKET, 5'd0, 3'd0, 8'd6, 32'h0A00_0001, 8'd0, 16'd1234,
                   32'h0, 8'd0, 16'd80, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd4, 8'd6, 32'h0A00_0001, 8'd0, 16'd1234,
                   32'h1234_5678, 8'd0, 16'd80, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd4, 8'd6, 32'h0A00_0002, 8'd0, 16'd1234,
                   32'h1234_5678, 8'd0, 16'd80, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd6, 8'd17, 32'hC0A8_3703, 8'd0, 16'h1111,
                   32'hFFFF_FFFF, 8'd0, 16'h2222, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd6, 8'd17, 32'hC0A8_3703, 8'd0, 16'h1111,
                   32'hFFFF_FFFE, 8'd0, 16'h2222, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd6, 8'd0, 32'hFFFF_0000, 8'd0, 16'hFFFF,
                   32'hC0A8_0101, 8'd0, 16'd0, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd4, 8'hFF, 32'hFFFF_FFFF, 8'd0, 16'd1,
                   32'h0102_0304, 8'd0, 16'hFFFF, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd4, 8'hFF, 32'hFFFF_FFFF, 8'd0, 16'd1,
                   32'h0102_0305, 8'd0, 16'hFFFF, 8'h0, 2'd0));
    send_item(flow(KIND_PACKET, 5'd0, 3'd5, 8'h80, 32'h5555_AAAA, 8'd0, 16'h00FF,
                   32'hAAAA_5555, 8'd0, 16'hFF00, 8'h0, 2'd0));
    set_rule_count(6'd4);
    send_item(flow(KIND_PACKET, 5'd0, 3'd5, 8'h80, 32'h5555_AAAA, 8'd0, 16'h00FF,
                   32'hAAAA_5555, 8'd0, 16'hFF00, 8'h0, 2'd0));

    // fill the whole table before any deeper search
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_item(random_rule(5'(i)));
    end

    phase = 0;
    while (issued < ITEM_TARGET) begin
      if (ITEM_TARGET - issued <= 150) begin
        calm = 1'b1;
        n = 6'd32;
        len = ITEM_TARGET - issued;
      end else begin
        n = (phase < 5) ? 6'(schedule[phase]) : 6'($urandom_range(0, 63));
        len = $urandom_range(80, 130);
      end
      set_rule_count(n);
      phase++;
      depth = (n > TABLE_DEPTH) ? TABLE_DEPTH : int'(n);
      repeat (len) begin
        k = $urandom_range(0, 99);
        if (k < 72) begin
          // packet built to hit a stored rule, sometimes with one field broken
          r = sb.rules[(depth > 0) ? $urandom_range(0, depth - 1) : $urandom_range(0, 31)];
          it = r;
          it.kind = KIND_PACKET;
          it.slot = 5'($urandom);
          if (r.version == 3'd0) it.version = 3'($urandom_range(1, 6));
          if (r.proto == 8'd0) it.proto = 8'($urandom);
          it.src_addr = fit_addr(r.src_addr, r.src_len);
          it.dst_addr = fit_addr(r.dst_addr, r.dst_len);
          if (r.src_port == 16'd0) it.src_port = 16'($urandom);
          if (r.dst_port == 16'd0) it.dst_port = 16'($urandom);
          it.src_len = 8'($urandom);
          it.dst_len = 8'($urandom);
          it.pair    = 8'($urandom);
          it.attr    = 2'($urandom);
          k = $urandom_range(0, 31);
          case ($urandom_range(0, 11))
            0: it.src_addr[k] = ~it.src_addr[k];
            1: it.dst_addr[k] = ~it.dst_addr[k];
            2: it.src_port[k % 16] = ~it.src_port[k % 16];
            3: it.dst_port[k % 16] = ~it.dst_port[k % 16];
            4: it.proto[k % 8] = ~it.proto[k % 8];
            5: it.version = 3'($urandom_range(0, 6));
            default: ;
          endcase
        end else if (k < 84) begin
          it = random_rule(5'($urandom));
          it.kind = KIND_PACKET;
          it.version = 3'($urandom_range(0, 6));
        end else begin
          it = random_rule(5'($urandom));
        end
        send_item(it);
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("first_match_flow_classifier test passed");
    end else begin
      $display("first_match_flow_classifier test failed");
    end
    $finish;
  end

endmodule
